### rtl/sat_pkg.sv
// Shared types and constants for the sorted array table.
// Used by sat_ram's users, sat_engine and sorted_array_table; depends on nothing.
`timescale 1ns / 1ps

package sat_pkg;

	localparam int TABLE_DEPTH_DEFAULT = 64;
	localparam int KEY_W = 32;
	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_EXISTS = 3'd1,
		OP_FIRST  = 3'd2,
		OP_LAST   = 3'd3,
		OP_COUNT  = 3'd4,
		OP_DEL1   = 3'd5,
		OP_DELALL = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SRCH_ADDR,
		ST_SRCH_CMP,
		ST_EVAL,
		ST_SHIFT,
		ST_INS_WR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       table_empty;
		logic       is_full;
		logic [6:0] entry_count;
		logic [6:0] match_count;
		logic [5:0] index;
		status_t    status;
	} res_t;

endpackage

### rtl/sat_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/sat_engine.sv
// Request sequencer: binary search over the table memory and entry shifting.
// Depends on sat_pkg; drives the ports of one sat_ram instance.
`timescale 1ns / 1ps

module sat_engine #(
	parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  sat_pkg::op_t                   req_op,
	input  logic [sat_pkg::KEY_W-1:0]      req_value,
	input  logic [6:0]                     cap_limit,
	output logic                           res_valid,
	input  logic                           res_ready,
	output sat_pkg::res_t                  res,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [sat_pkg::KEY_W-1:0]      ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [sat_pkg::KEY_W-1:0]      ram_rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (FW > 7) ? FW : 7;

	sat_pkg::state_t state_q, state_d;
	sat_pkg::op_t    op_q, op_d;
	sat_pkg::status_t status_q, status_d;
	logic signed [sat_pkg::KEY_W-1:0] key_q, key_d;
	logic [FW-1:0] lo_q, lo_d, hi_q, hi_d, lb_q, lb_d, fill_q, fill_d;
	logic [FW-1:0] rem_q, rem_d, dist_q, dist_d, mid;
	logic [AW-1:0] src_q, src_d, dst_s1, dst_d;
	logic [5:0]    index_q, index_d;
	logic [6:0]    match_q, match_d;
	logic          upper_q, upper_d, up_q, up_d, pend_s1, pend_d;
	logic          go_right;
	logic [CW-1:0] cap_eff;
	logic          is_full;

	assign cap_eff = (CW'(cap_limit) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cap_limit);
	assign is_full = CW'(fill_q) >= cap_eff;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign go_right = upper_q ? ($signed(ram_rdata) <= key_q) : ($signed(ram_rdata) < key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sat_pkg::ST_IDLE;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		key_q    <= key_d;
		status_q <= status_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		lb_q     <= lb_d;
		rem_q    <= rem_d;
		dist_q   <= dist_d;
		src_q    <= src_d;
		dst_s1   <= dst_d;
		index_q  <= index_d;
		match_q  <= match_d;
		upper_q  <= upper_d;
		up_q     <= up_d;
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		key_d    = key_q;
		status_d = status_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		lb_d     = lb_q;
		fill_d   = fill_q;
		rem_d    = rem_q;
		dist_d   = dist_q;
		src_d    = src_q;
		dst_d    = dst_s1;
		index_d  = index_q;
		match_d  = match_q;
		upper_d  = upper_q;
		up_d     = up_q;
		pend_d   = 1'b0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = src_q;

		case (state_q)
			sat_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op_d    = req_op;
					key_d   = req_value;
					state_d = sat_pkg::ST_DISPATCH;
				end
			end
			sat_pkg::ST_DISPATCH: begin
				status_d = sat_pkg::STAT_OK;
				index_d  = '0;
				match_d  = '0;
				lo_d     = '0;
				hi_d     = fill_q;
				upper_d  = 1'b0;
				if (op_q == sat_pkg::OP_CLEAR) begin
					fill_d  = '0;
					state_d = sat_pkg::ST_FIN;
				end else if (op_q == sat_pkg::OP_INSERT && is_full) begin
					status_d = sat_pkg::STAT_FULL;
					state_d  = sat_pkg::ST_FIN;
				end else begin
					state_d = sat_pkg::ST_SRCH_ADDR;
				end
			end
			sat_pkg::ST_SRCH_ADDR: begin
				if (lo_q < hi_q) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(mid);
					state_d   = sat_pkg::ST_SRCH_CMP;
				end else if (upper_q) begin
					state_d = sat_pkg::ST_EVAL;
				end else begin
					lb_d = lo_q;
					if (op_q == sat_pkg::OP_INSERT) begin
						rem_d   = fill_q - lo_q;
						src_d   = AW'(fill_q - FW'(1));
						up_d    = 1'b1;
						state_d = sat_pkg::ST_SHIFT;
					end else begin
						upper_d = 1'b1;
						hi_d    = fill_q;
					end
				end
			end
			sat_pkg::ST_SRCH_CMP: begin
				if (go_right) begin
					lo_d = mid + FW'(1);
				end else begin
					hi_d = mid;
				end
				state_d = sat_pkg::ST_SRCH_ADDR;
			end
			sat_pkg::ST_EVAL: begin
				// Here lo_q holds the upper bound and lb_q the lower bound.
				state_d = sat_pkg::ST_FIN;
				rem_d   = fill_q - lo_q;
				src_d   = AW'(lo_q);
				up_d    = 1'b0;
				dist_d  = FW'(1);
				if (lo_q == lb_q) begin
					status_d = sat_pkg::STAT_NOT_FOUND;
				end else begin
					case (op_q)
						sat_pkg::OP_FIRST: index_d = 6'(lb_q);
						sat_pkg::OP_LAST:  index_d = 6'(lo_q - FW'(1));
						sat_pkg::OP_COUNT: match_d = 7'(lo_q - lb_q);
						sat_pkg::OP_DEL1:  state_d = sat_pkg::ST_SHIFT;
						sat_pkg::OP_DELALL: begin
							match_d = 7'(lo_q - lb_q);
							dist_d  = lo_q - lb_q;
							state_d = sat_pkg::ST_SHIFT;
						end
						default: ;
					endcase
				end
			end
			sat_pkg::ST_SHIFT: begin
				// Reads run one entry ahead of writes; the read side never
				// touches an address that a pending write targets.
				if (pend_s1) begin
					ram_we = 1'b1;
				end
				if (rem_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = src_q;
					pend_d    = 1'b1;
					rem_d     = rem_q - FW'(1);
					if (up_q) begin
						dst_d = src_q + AW'(1);
						src_d = src_q - AW'(1);
					end else begin
						dst_d = src_q - AW'(dist_q);
						src_d = src_q + AW'(1);
					end
				end else if (!pend_s1) begin
					if (up_q) begin
						state_d = sat_pkg::ST_INS_WR;
					end else begin
						fill_d  = fill_q - dist_q;
						state_d = sat_pkg::ST_FIN;
					end
				end
			end
			sat_pkg::ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(lb_q);
				ram_wdata = key_q;
				fill_d    = fill_q + FW'(1);
				state_d   = sat_pkg::ST_FIN;
			end
			sat_pkg::ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = sat_pkg::ST_IDLE;
				end
			end
			default: state_d = sat_pkg::ST_IDLE;
		endcase
	end

	assign res.status      = status_q;
	assign res.index       = index_q;
	assign res.match_count = match_q;
	assign res.entry_count = 7'(fill_q);
	assign res.is_full     = is_full;
	assign res.table_empty = (fill_q == '0);

endmodule

### rtl/sorted_array_table.sv
// Top level of the sorted array table: stream ports, capacity register, result register.
// Depends on sat_pkg, sat_ram and sat_engine.
//
// Channel   | Direction | Handshake               | Contents
// s_axis    | in        | s_axis_tvalid/tready    | tuser: op; tdata: value
// m_axis    | out       | m_axis_tvalid/tready    | tuser: status; tdata: result fields
// cfg       | in        | cfg_we                  | cfg_data: capacity_limit
//
// A request is taken only when the sequencer is idle; its result lands in an output
// register, so the next request may be taken while that result waits.
// Clear and an insert into a full table skip the search. Other ops run binary searches of p
// probes each, where p <= floor(log2(fill))+1: insert runs one (lower bound) and then moves
// the m entries at and above that position up by one; every other op runs two (lower and
// upper bound), and removal then moves the entries above the matches down.
// While the output register holds a result that m_axis does not take, a finished request waits.
// Reset empties the table at once; no memory sweep is needed.
`timescale 1ns / 1ps

module sorted_array_table #(
	parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [2:0]  s_axis_tuser,  // [2:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [5:0] index, [12:6] match_count,
	                                   // [19:13] entry_count, [20] is_full, [21] table_empty
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [6:0]           cap_q;
	logic                 out_valid_q;
	sat_pkg::res_t        out_q;
	sat_pkg::res_t        res;
	logic                 res_valid, res_ready;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [sat_pkg::KEY_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= sat_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {2'b00, out_q.table_empty, out_q.is_full, out_q.entry_count,
	                        out_q.match_count, out_q.index};

	sat_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_op    (sat_pkg::op_t'(s_axis_tuser)),
		.req_value (s_axis_tdata),
		.cap_limit (cap_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	sat_ram #(
		.WIDTH(sat_pkg::KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
